FILE: rtl/assert_macros.svh
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMP(lbl, clk_s, rst_s, a, c) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |-> (c)) else $error("lbl");
`define AST_NXT(lbl, clk_s, rst_s, a, c) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |=> (c)) else $error("lbl");
`else
`define AST_IMP(lbl, clk_s, rst_s, a, c)
`define AST_NXT(lbl, clk_s, rst_s, a, c)
`endif
`endif

FILE: rtl/ffra_pkg.sv
// Types and codes of the first-fit range allocator.
package ffra_pkg;
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_LEN  = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    K_ALLOC     = 2'd0,
    K_FREE_EXACT = 2'd1,
    K_FREE_BASE = 2'd2,
    K_QUERY     = 2'd3
  } kind_t;

  localparam int unsigned REG_BASE = 0;
  localparam int unsigned REG_LEN  = 1;
endpackage

FILE: rtl/first_fit_range_allocator.sv
// First-fit range allocator: free and used range lists with a scan sequencer.
//
//  channel  | dir | payload
//  s_axis   | in  | tdata {req_length, address}, tuser kind
//  m_axis   | out | tdata {in_use, granted_length, granted_base, status}
//  apb      | in  | region_base at 0x0, region_length at 0x4
//
// One item at a time. Each scanned list entry takes a memory read state, then a
// compare state; a removal shifts the tail one entry at a time, a read state then
// a write state per entry. After rst the S_INIT state writes free entry 0 before
// the first item is taken. A result held by m_axis_tready stalls the sequencer
// before its next item.
`include "assert_macros.svh"
module first_fit_range_allocator
  import ffra_pkg::*;
#(
  parameter int unsigned MAX_FREE = 64,
  parameter int unsigned MAX_USED = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] address, [63:32] req_length
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [2:0] status, [34:3] granted_base,
                                      // [66:35] granted_length, [67] in_use
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int FW  = $clog2(MAX_FREE);
  localparam int UW  = $clog2(MAX_USED);
  localparam int CFW = $clog2(MAX_FREE + 1);
  localparam int CUW = $clog2(MAX_USED + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CHK, S_FRD, S_FCMP, S_FSH_RD, S_FSH_WR,
    S_URD, S_UCMP, S_USH_RD, S_USH_WR, S_DONE
  } state_t;

  state_t         state;
  logic [31:0]    region_base, region_length;
  logic [CFW-1:0] free_count, fi;
  logic [CUW-1:0] used_count, ui;
  kind_t          kind;
  logic [31:0]    addr, req_len;
  status_t        st;
  logic [31:0]    g_base, g_len;
  logic           hit;
  logic [63:0]    frd, urd;       // {base, length}
  logic [63:0]    free_mem [MAX_FREE];
  logic [63:0]    used_mem [MAX_USED];

  status_t        o_status;
  logic [31:0]    o_base, o_len;
  logic           o_in_use;

  logic           cfg_wr;
  logic           fwe, uwe;
  logic [FW-1:0]  fwa;
  logic [UW-1:0]  uwa;
  logic [63:0]    fwd, uwd;

  logic [32:0]    reg_end, x_end;
  logic           addr_in, end_in;
  logic [31:0]    f_base, f_len, u_base, u_len;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? region_length : region_base;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {4'd0, o_in_use, o_len, o_base, o_status};

  assign f_base  = frd[63:32];
  assign f_len   = frd[31:0];
  assign u_base  = urd[63:32];
  assign u_len   = urd[31:0];
  assign reg_end = {1'b0, region_base} + {1'b0, region_length};
  assign x_end   = {1'b0, addr} + {1'b0, req_len} - 33'd1;
  assign addr_in = (addr >= region_base) && ({1'b0, addr} < reg_end);
  assign end_in  = (x_end >= {1'b0, region_base}) && (x_end < reg_end);

  // memory write ports
  always_comb begin
    fwe = 1'b0; fwa = '0; fwd = '0;
    uwe = 1'b0; uwa = '0; uwd = '0;
    if (cfg_wr) begin
      fwe = 1'b1;
      fwd = paddr[2] ? {region_base, pwdata} : {pwdata, region_length};
    end else if (state == S_INIT) begin
      fwe = 1'b1;
      fwd = {region_base, region_length};
    end else begin
      unique case (state)
        S_FCMP: begin
          if (f_len >= req_len && used_count < CUW'(MAX_USED)) begin
            uwe = 1'b1;
            uwa = used_count[UW-1:0];
            uwd = {f_base, req_len};
            if (f_len != req_len) begin
              fwe = 1'b1;
              fwa = fi[FW-1:0];
              fwd = {f_base + req_len, f_len - req_len};
            end
          end
        end
        S_FSH_WR: begin
          fwe = 1'b1; fwa = fi[FW-1:0]; fwd = frd;
        end
        S_UCMP: begin
          if (kind != K_QUERY && u_base == addr &&
              (kind == K_FREE_BASE || u_len == req_len) &&
              free_count < CFW'(MAX_FREE)) begin
            fwe = 1'b1; fwa = free_count[FW-1:0]; fwd = urd;
          end
        end
        S_USH_WR: begin
          uwe = 1'b1; uwa = ui[UW-1:0]; uwd = urd;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fwe) free_mem[fwa] <= fwd;
    if (uwe) used_mem[uwa] <= uwd;
    if (state == S_FRD)    frd <= free_mem[fi[FW-1:0]];
    if (state == S_FSH_RD) frd <= free_mem[FW'(fi + CFW'(1))];
    if (state == S_URD)    urd <= used_mem[ui[UW-1:0]];
    if (state == S_USH_RD) urd <= used_mem[UW'(ui + CUW'(1))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      region_base   <= '0;
      region_length <= '0;
      free_count    <= CFW'(1);
      used_count    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // S_DONE refills the output register itself
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) m_axis_tvalid <= 1'b0;
      if (cfg_wr) begin
        if (paddr[2]) region_length <= pwdata;
        else          region_base   <= pwdata;
        free_count <= CFW'(1);
        used_count <= '0;
      end
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (s_axis_tvalid) begin
            kind    <= kind_t'(s_axis_tuser);
            addr    <= s_axis_tdata[31:0];
            req_len <= s_axis_tdata[63:32];
            state   <= S_CHK;
          end
        end
        S_CHK: begin
          st <= ST_OK; g_base <= '0; g_len <= '0; hit <= 1'b0;
          fi <= '0; ui <= '0;
          unique case (kind)
            K_ALLOC: begin
              if (req_len == '0) begin
                st <= ST_ZERO_LEN; state <= S_DONE;
              end else begin
                state <= S_FRD;
              end
            end
            K_QUERY: state <= S_URD;
            default: begin
              if (kind == K_FREE_EXACT && req_len == '0) begin
                st <= ST_ZERO_LEN; state <= S_DONE;
              end else if (!addr_in || (kind == K_FREE_EXACT && !end_in)) begin
                st <= ST_OUTSIDE; state <= S_DONE;
              end else begin
                state <= S_URD;
              end
            end
          endcase
        end
        S_FRD: begin
          if (fi >= free_count) begin
            st <= ST_NO_FIT; state <= S_DONE;
          end else begin
            state <= S_FCMP;
          end
        end
        S_FCMP: begin
          if (f_len >= req_len) begin
            if (used_count >= CUW'(MAX_USED)) begin
              st <= ST_FULL; state <= S_DONE;
            end else begin
              g_base     <= f_base;
              g_len      <= req_len;
              used_count <= used_count + CUW'(1);
              state      <= (f_len == req_len) ? S_FSH_RD : S_DONE;
            end
          end else begin
            fi    <= fi + CFW'(1);
            state <= S_FRD;
          end
        end
        S_FSH_RD: begin
          if (fi + CFW'(1) >= free_count) begin
            free_count <= free_count - CFW'(1);
            state      <= S_DONE;
          end else begin
            state <= S_FSH_WR;
          end
        end
        S_FSH_WR: begin
          fi    <= fi + CFW'(1);
          state <= S_FSH_RD;
        end
        S_URD: begin
          if (ui >= used_count) begin
            if (kind != K_QUERY) st <= ST_NOT_FOUND;
            state <= S_DONE;
          end else begin
            state <= S_UCMP;
          end
        end
        S_UCMP: begin
          if (kind == K_QUERY) begin
            if ({1'b0, addr} >= {1'b0, u_base} &&
                {1'b0, addr} < ({1'b0, u_base} + {1'b0, u_len})) begin
              hit <= 1'b1; state <= S_DONE;
            end else begin
              ui <= ui + CUW'(1); state <= S_URD;
            end
          end else if (u_base == addr && (kind == K_FREE_BASE || u_len == req_len)) begin
            if (free_count >= CFW'(MAX_FREE)) begin
              st <= ST_FULL; state <= S_DONE;
            end else begin
              free_count <= free_count + CFW'(1);
              state      <= S_USH_RD;
            end
          end else begin
            ui <= ui + CUW'(1); state <= S_URD;
          end
        end
        S_USH_RD: begin
          if (ui + CUW'(1) >= used_count) begin
            used_count <= used_count - CUW'(1);
            state      <= S_DONE;
          end else begin
            state <= S_USH_WR;
          end
        end
        S_USH_WR: begin
          ui    <= ui + CUW'(1);
          state <= S_USH_RD;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            o_status      <= st;
            o_base        <= g_base;
            o_len         <= g_len;
            o_in_use      <= hit;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AST_IMP(free_cnt_bound, clk, rst, 1'b1, free_count <= CFW'(MAX_FREE))
  `AST_IMP(used_cnt_bound, clk, rst, 1'b1, used_count <= CUW'(MAX_USED))
  `AST_NXT(busy_after_take, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `AST_IMP(grant_only_ok, clk, rst, m_axis_tvalid && o_status != ST_OK, o_len == '0)
endmodule

FILE: dv/tb_first_fit_range_allocator.sv
// Testbench for the first-fit range allocator: directed and random checks against a predictor.
`timescale 1ns / 1ps
module tb_first_fit_range_allocator;
  import ffra_pkg::*;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned STALL_LIMIT = 8000;
  localparam int unsigned SETTLE_CYCLES = 300;

  typedef struct packed {
    status_t     status;
    logic [31:0] granted_base;
    logic [31:0] granted_length;
    logic        in_use;
  } grant_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [31:0] address, [63:32] req_length
  logic [1:0]  s_axis_tuser;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // [2:0] status, [34:3] granted_base,
                               // [66:35] granted_length, [67] in_use
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  first_fit_range_allocator dut (.*);

  // allocator shadow state
  logic [31:0] region_base_q, region_len_q;
  logic [31:0] free_base [LIST_DEPTH];
  logic [31:0] free_len  [LIST_DEPTH];
  int unsigned free_cnt;
  logic [31:0] used_base [LIST_DEPTH];
  logic [31:0] used_len  [LIST_DEPTH];
  int unsigned used_cnt;

  grant_t      pending_grants[$];
  int unsigned mismatches = 0;
  int unsigned beats_in;
  int unsigned beats_out = 0;
  int unsigned status_seen[8];
  int unsigned idle_cycles = 0;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reinit_lists();
    free_base[0] = region_base_q;
    free_len[0] = region_len_q;
    free_cnt = 1;
    used_cnt = 0;
  endfunction

  function automatic bit in_region(logic [32:0] a);
    return a >= {1'b0, region_base_q} && a < {1'b0, region_base_q} + {1'b0, region_len_q};
  endfunction

  function automatic grant_t apply_request(kind_t k, logic [31:0] a, logic [31:0] l);
    grant_t g;
    int unsigned i;
    g = '{ST_OK, 32'd0, 32'd0, 1'b0};
    case (k)
      K_ALLOC: begin
        if (l == 0) begin
          g.status = ST_ZERO_LEN;
        end else begin
          for (i = 0; i < free_cnt; i++)
            if (free_len[i] >= l) break;
          if (i >= free_cnt) g.status = ST_NO_FIT;
          else if (used_cnt >= LIST_DEPTH) g.status = ST_FULL;
          else begin
            g.granted_base = free_base[i];
            g.granted_length = l;
            used_base[used_cnt] = free_base[i];
            used_len[used_cnt] = l;
            used_cnt++;
            if (free_len[i] == l) begin
              for (int j = i; j + 1 < free_cnt; j++) begin
                free_base[j] = free_base[j+1];
                free_len[j] = free_len[j+1];
              end
              free_cnt--;
            end else begin
              free_base[i] = free_base[i] + l;
              free_len[i] = free_len[i] - l;
            end
          end
        end
      end
      K_FREE_EXACT, K_FREE_BASE: begin
        if (k == K_FREE_EXACT && l == 0) begin
          g.status = ST_ZERO_LEN;
        end else if (!in_region({1'b0, a}) ||
                     (k == K_FREE_EXACT && !in_region({1'b0, a} + {1'b0, l} - 33'd1))) begin
          g.status = ST_OUTSIDE;
        end else begin
          for (i = 0; i < used_cnt; i++)
            if (used_base[i] == a && (k == K_FREE_BASE || used_len[i] == l)) break;
          if (i >= used_cnt) g.status = ST_NOT_FOUND;
          else if (free_cnt >= LIST_DEPTH) g.status = ST_FULL;
          else begin
            free_base[free_cnt] = used_base[i];
            free_len[free_cnt] = used_len[i];
            free_cnt++;
            for (int j = i; j + 1 < used_cnt; j++) begin
              used_base[j] = used_base[j+1];
              used_len[j] = used_len[j+1];
            end
            used_cnt--;
          end
        end
      end
      default: begin
        for (i = 0; i < used_cnt; i++)
          if ({1'b0, a} >= {1'b0, used_base[i]} &&
              {1'b0, a} < {1'b0, used_base[i]} + {1'b0, used_len[i]}) begin
            g.in_use = 1'b1;
            break;
          end
      end
    endcase
    return g;
  endfunction

  task automatic send_request(kind_t k, logic [31:0] a, logic [31:0] l);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {l, a};
    s_axis_tuser <= k;
    do @(posedge clk); while (!s_axis_tready);
    pending_grants.push_back(apply_request(k, a, l));
    beats_in++;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle, then access cycle; the register takes the value at the access edge
  task automatic write_reg(int unsigned idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_BASE) region_base_q = value;
    else region_len_q = value;
    reinit_lists();
  endtask

  task automatic set_region(logic [31:0] b, logic [31:0] l);
    drain();
    write_reg(REG_BASE, b);
    write_reg(REG_LEN, l);
  endtask

  // result checker
  always @(posedge clk) begin
    grant_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = grant_t'({m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[66:35],
                      m_axis_tdata[67]});
      beats_out++;
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = pending_grants.pop_front();
        status_seen[want.status]++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // receiver backpressure in bursts
  initial begin
    int unsigned n;
    m_axis_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic test_reset_region();
    // empty region after reset: nothing fits, nothing is inside
    send_request(K_ALLOC, 32'd0, 32'd1);
    send_request(K_FREE_BASE, 32'd0, 32'd0);
    send_request(K_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed();
    set_region(32'h100, 32'h100);
    send_request(K_ALLOC, 32'd0, 32'd0);
    send_request(K_ALLOC, 32'd0, 32'h40);
    send_request(K_ALLOC, 32'd0, 32'h101);
    send_request(K_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_request(K_QUERY, 32'h13F, 32'd0);
    send_request(K_QUERY, 32'h140, 32'd0);
    send_request(K_FREE_EXACT, 32'h100, 32'd0);
    send_request(K_FREE_EXACT, 32'h100, 32'h40);
    send_request(K_ALLOC, 32'd0, 32'h20);
    send_request(K_FREE_EXACT, 32'h140, 32'h20);
    send_request(K_FREE_EXACT, 32'hFF, 32'h10);
    send_request(K_FREE_EXACT, 32'h1F0, 32'h20);
    send_request(K_FREE_BASE, 32'h200, 32'd0);
    send_request(K_FREE_BASE, 32'h140, 32'hFFFF_FFFF);
    send_request(K_ALLOC, 32'd0, 32'h40);  // first fit splits the first free range, not the freed one
    send_request(K_FREE_BASE, 32'h140, 32'd0);
    // region that wraps past the top of the address space
    set_region(32'hFFFF_FFF0, 32'h100);
    send_request(K_ALLOC, 32'd0, 32'h10);
    send_request(K_ALLOC, 32'd0, 32'h8);
    send_request(K_QUERY, 32'hFFFF_FFFF, 32'd0);
    send_request(K_QUERY, 32'd0, 32'd0);
    send_request(K_FREE_BASE, 32'd0, 32'd0);
    set_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(K_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_request(K_FREE_EXACT, 32'hFFFF_FFFF, 32'h1);
  endtask

  task automatic test_tables_full();
    set_region(32'h1000, 32'h1000);
    for (int i = 0; i < LIST_DEPTH; i++) send_request(K_ALLOC, 32'd0, 32'd1);
    send_request(K_ALLOC, 32'd0, 32'd1);
    for (int i = 0; i < LIST_DEPTH - 1; i++) send_request(K_FREE_BASE, 32'h1000 + i, 32'd0);
    send_request(K_FREE_EXACT, 32'h1000 + LIST_DEPTH - 1, 32'd1);
  endtask

  task automatic random_burst(int unsigned count);
    int unsigned r, idx;
    logic [31:0] a, l;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        if ($urandom_range(0, 9) == 0) l = $urandom;
        else l = $urandom_range(1, region_len_q / 24 + 1);
        send_request(K_ALLOC, $urandom, l);
      end else if (r < 75 && used_cnt != 0) begin
        idx = $urandom_range(0, used_cnt - 1);
        if (r < 58) send_request(K_FREE_EXACT, used_base[idx], used_len[idx]);
        else send_request(K_FREE_BASE, used_base[idx], $urandom);
      end else if (r < 90 && used_cnt != 0) begin
        idx = $urandom_range(0, used_cnt - 1);
        a = used_base[idx] + $urandom_range(0, 2) * (used_len[idx] - 1) / 2;
        if ($urandom_range(0, 3) == 0) a = a + used_len[idx];
        send_request(K_QUERY, a, $urandom);
      end else begin
        send_request(kind_t'($urandom_range(0, 3)), $urandom, $urandom);
      end
      // hold off now and then until every grant is back
      if (n % 250 == 249) begin
        s_axis_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge clk);
      end
    end
  endtask

  task automatic test_random();
    set_region(32'h1000, 32'h1000);
    random_burst(300);
    set_region(32'd0, 32'hFFFF_FFFF);
    random_burst(300);
    set_region(32'hFFFF_F000, 32'h2000);
    random_burst(300);
    set_region(32'h8000_0000, 32'h0000_0400);
    random_burst(300);
    no_idle = 1'b1;
    set_region($urandom, $urandom_range(64, 65536));
    random_burst(300);
  endtask

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    beats_in = 0;
    no_idle = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    region_base_q = '0;
    region_len_q = '0;
    reinit_lists();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_region();
    test_directed();
    test_tables_full();
    test_random();
    drain();
    $display("covered %0d requests, %0d grants over several regions incl. wrap and full tables",
             beats_in, beats_out);
    $display("status counts ok %0d zero %0d nofit %0d outside %0d notfound %0d full %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
